[sv/osrb_pkg.sv]
package osrb_pkg;

	// Store geometry
	localparam int FRAME_SAMPLES          = 8;
	localparam int BUFFER_FRAMES          = 32;
	localparam int MAX_FRAMES_PER_REQUEST = 8;
	localparam int CAPACITY               = FRAME_SAMPLES * BUFFER_FRAMES;

	localparam int PTR_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int WANT_W  = 4;
	localparam int GRANT_W = 7;
	localparam int IDX_W   = 6;

	// Operation codes
	localparam logic OP_PUSH    = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	typedef struct packed {
		logic                op;
		logic signed [31:0]  sample_in;
		logic                block_end;
		logic [WANT_W-1:0]   frames_wanted;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0]  sample_out;
		logic                sample_valid;
		logic                frame_end;
		logic                last;
		logic [GRANT_W-1:0]  samples_granted;
		logic [CNT_W-1:0]    held_count;
		logic                is_full;
		logic                is_empty;
	} out_word_t;

	// Decoded command handed from front to back
	typedef struct packed {
		logic                op;
		logic signed [31:0]  sample;
		logic                block_end;
		logic [WANT_W-1:0]   want;
		logic                want_zero;
	} cmd_t;

	// Command queue status seen by the front
	typedef struct packed {
		logic full;
		logic valid;
	} cmdq_status_t;

	// Per-result tags carried alongside the memory read
	typedef struct packed {
		logic                is_sample;
		logic                frame_end;
		logic                last;
		logic [GRANT_W-1:0]  granted;
	} res_meta_t;

	typedef enum logic {
		B_IDLE,
		B_STREAM
	} back_state_t;

endpackage

[sv/osrb_front.sv]
module osrb_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  osrb_pkg::in_word_t in_word,
	input  osrb_pkg::cmdq_status_t q_status,
	output logic              push_en,
	output osrb_pkg::cmd_t    push_cmd
);
	import osrb_pkg::*;

	logic [WANT_W-1:0] want_clamped;

	// Stall only on a full queue; valid never looks at it
	assign in_stall = q_status.full;
	assign push_en  = in_valid && !q_status.full;

	// Clamp oversized requests
	always_comb begin
		if (in_word.frames_wanted > WANT_W'(MAX_FRAMES_PER_REQUEST)) begin
			want_clamped = WANT_W'(MAX_FRAMES_PER_REQUEST);
		end else begin
			want_clamped = in_word.frames_wanted;
		end
	end

	// Classify the word
	always_comb begin
		push_cmd.op        = in_word.op;
		push_cmd.sample    = in_word.sample_in;
		push_cmd.block_end = in_word.block_end;
		push_cmd.want      = want_clamped;
		push_cmd.want_zero = (in_word.frames_wanted == '0);
	end

endmodule

[sv/osrb_cmd_q.sv]
module osrb_cmd_q (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  osrb_pkg::cmd_t         wr_cmd,
	output osrb_pkg::cmdq_status_t status,
	input  logic                   rd_pop,
	output osrb_pkg::cmd_t         rd_cmd
);
	import osrb_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.valid = (count_q != 2'd0);
	assign rd_cmd       = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_pop};
		end
	end

endmodule

[sv/osrb_back.sv]
module osrb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  osrb_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output osrb_pkg::out_word_t out_word
);
	import osrb_pkg::*;

	// Sample memory, written by pushes, read while streaming
	logic [31:0] mem [CAPACITY];

	back_state_t        state_q, state_d;
	logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic               full_q, full_d, empty_q, empty_d;
	logic [GRANT_W-1:0] granted_q, granted_d;
	logic [IDX_W-1:0]   idx_q, idx_d;

	logic               mem_we, rd_en;
	logic               issue;
	res_meta_t          issue_meta;

	logic               valid_s1;
	res_meta_t          meta_s1;
	logic [31:0]        rdata_s1;

	out_word_t          buf_q [2];
	logic               bwr_q, brd_q;
	logic [1:0]         occ_q;
	logic               pop;
	logic [2:0]         occ_after;
	logic               issue_ok;
	out_word_t          res;

	logic [CNT_W-1:0]   avail;
	logic [WANT_W-1:0]  frames;
	logic [GRANT_W-1:0] total;
	logic               s_last, s_fend;

	// Output buffer handshake and room check
	assign pop       = out_valid && !out_stall;
	assign occ_after = {1'b0, occ_q} + {2'b0, valid_s1} - {2'b0, pop};
	assign issue_ok  = (occ_after < 3'd2);
	assign out_valid = (occ_q != 2'd0);
	assign out_word  = buf_q[brd_q];

	// Pointer wrap
	assign wp_inc = (wp_q == PTR_W'(CAPACITY - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PTR_W'(CAPACITY - 1)) ? '0 : rp_q + 1'b1;

	// Grant size for a dequeue
	assign avail  = fill_q / CNT_W'(FRAME_SAMPLES);
	assign frames = ({{(CNT_W-WANT_W){1'b0}}, cmd.want} < avail) ? cmd.want : WANT_W'(avail);
	assign total  = GRANT_W'(frames) * GRANT_W'(FRAME_SAMPLES);

	// Stream position tags
	assign s_last = (({1'b0, idx_q} + GRANT_W'(1)) == granted_q);
	assign s_fend = ((idx_q % IDX_W'(FRAME_SAMPLES)) == IDX_W'(FRAME_SAMPLES - 1));

	// Sequencer: next state and command execution
	always_comb begin
		state_d    = state_q;
		wp_d       = wp_q;
		rp_d       = rp_q;
		fill_d     = fill_q;
		full_d     = full_q;
		empty_d    = empty_q;
		granted_d  = granted_q;
		idx_d      = idx_q;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		issue      = 1'b0;
		issue_meta = '0;
		cmd_pop    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid && issue_ok) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_PUSH) begin
						mem_we = 1'b1;
						wp_d   = wp_inc;
						if ((fill_q + 1'b1) >= CNT_W'(CAPACITY)) begin
							full_d = 1'b1;
							rp_d   = wp_inc;
							fill_d = CNT_W'(CAPACITY);
						end else begin
							fill_d = fill_q + 1'b1;
						end
						empty_d = (fill_d == '0);
						if (cmd.block_end) begin
							issue           = 1'b1;
							issue_meta.last = 1'b1;
						end
					end else if (fill_q < CNT_W'(FRAME_SAMPLES) || cmd.want_zero) begin
						// nothing to hand out
						issue           = 1'b1;
						issue_meta.last = 1'b1;
					end else begin
						full_d    = 1'b0;
						fill_d    = fill_q - CNT_W'(total);
						empty_d   = (fill_d == '0);
						granted_d = total;
						idx_d     = '0;
						state_d   = B_STREAM;
					end
				end
			end
			B_STREAM: begin
				if (issue_ok) begin
					rd_en                = 1'b1;
					rp_d                 = rp_inc;
					issue                = 1'b1;
					issue_meta.is_sample = 1'b1;
					issue_meta.frame_end = s_fend;
					issue_meta.last      = s_last;
					issue_meta.granted   = granted_q;
					idx_d                = idx_q + 1'b1;
					if (s_last) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Sample memory port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= cmd.sample;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rp_q];
		end
	end

	// Result tags are registered in step with the memory read data
	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1 <= issue_meta;
		end
	end

	// Result word; status fields read after the step has landed
	always_comb begin
		res.sample_out      = meta_s1.is_sample ? rdata_s1 : '0;
		res.sample_valid    = meta_s1.is_sample;
		res.frame_end       = meta_s1.frame_end;
		res.last            = meta_s1.last;
		res.samples_granted = meta_s1.granted;
		res.held_count      = fill_q;
		res.is_full         = full_q;
		res.is_empty        = empty_q;
	end

	// Output buffer storage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			buf_q[bwr_q] <= res;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			full_q    <= 1'b0;
			empty_q   <= 1'b1;
			granted_q <= '0;
			idx_q     <= '0;
			valid_s1  <= 1'b0;
			bwr_q     <= 1'b0;
			brd_q     <= 1'b0;
			occ_q     <= 2'd0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			fill_q    <= fill_d;
			full_q    <= full_d;
			empty_q   <= empty_d;
			granted_q <= granted_d;
			idx_q     <= idx_d;
			valid_s1  <= issue;
			if (valid_s1) begin
				bwr_q <= ~bwr_q;
			end
			if (pop) begin
				brd_q <= ~brd_q;
			end
			occ_q <= 2'(occ_after);
		end
	end

endmodule

[sv/overwriting_sample_ring_buffer.sv]
// Overwriting ring buffer of 256 signed 32-bit samples (32 frames of 8). A push
// word stores one sample and, once the store is full, overwrites the oldest one;
// only a push marked block_end returns a word (a status word). A dequeue word
// returns one empty word when fewer than 8 samples are held or zero frames are
// asked for, and otherwise streams min(frames_wanted, held/8) whole frames, one
// sample per word, requests above 8 frames being clamped to 8. Every returned
// word reports held count and full/empty flags as they stand after the step.
// Words pass through a two-entry command queue into an in-order sequencer that
// owns the single-port sample memory; a word is registered in the queue before
// the sequencer can take it. A push or an empty dequeue is handled in a single
// sequencer step; a streaming dequeue has a setup step and then issues its
// samples one by one. A status or empty word passes through the result
// register and the output buffer; a streamed sample passes through the memory
// read register and the output buffer, after the setup step. The sequencer
// waits while the two-entry output buffer has no room, so a stalled receiver
// stalls it, and a full command queue stalls the sender. The sample memory is
// not cleared; the fill count keeps reads to written entries only.
module overwriting_sample_ring_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  osrb_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output osrb_pkg::out_word_t out_word
);
	import osrb_pkg::*;

	cmdq_status_t q_status;
	logic         push_en;
	cmd_t         push_cmd;
	cmd_t         head_cmd;
	logic         cmd_pop;

	// Accept and classify
	osrb_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_status (q_status),
		.push_en  (push_en),
		.push_cmd (push_cmd)
	);

	// Decoupling queue
	osrb_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push_en),
		.wr_cmd (push_cmd),
		.status (q_status),
		.rd_pop (cmd_pop),
		.rd_cmd (head_cmd)
	);

	// Execute against the store
	osrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_status.valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
